// File: rtl/core/mi_pkg.sv
// shared types and constants for the modular inverse block
package mi_pkg;

   // width of the item fields on the ports
   localparam int FIELD_W = 32;
   // default operand width of the datapath
   localparam int DEF_WIDTH = 32;

   typedef struct packed {
      logic [FIELD_W-1:0] value;
      logic [FIELD_W-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] inverse;
      logic               no_inverse;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/core/modular_inverse_top.sv
// modular inverse by the extended Euclidean algorithm, shared shift-subtract divider
// One item at a time: the value is reduced modulo the modulus, then Euclid quotient
// steps run until the remainder is zero, and one result item comes out with the
// inverse in [0, modulus) or the no-inverse flag (modulus zero, value a multiple of
// the modulus, or gcd above one; the inverse then reads 0). A modulus of one gives 1.
// All division goes through one restoring shift-subtract unit that retires one
// quotient bit per cycle and builds quotient times coefficient in the same pass,
// and each division is followed by one update step. A modulus of zero or one skips
// the division and goes straight to the finish state. req_ready is high only while
// the block is idle; a finished item waits in the output register and does not
// hold off the next input.
module modular_inverse_top #(
   parameter int WIDTH = mi_pkg::DEF_WIDTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  mi_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output mi_pkg::rsp_type rsp_data
);

   localparam int EXT_W = (WIDTH > mi_pkg::FIELD_W) ? WIDTH : mi_pkg::FIELD_W;
   localparam int CNT_W = $clog2(WIDTH);

   mi_pkg::state_type state_ff, state_in;

   logic [WIDTH-1:0] mod_ff, mod_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [WIDTH-1:0] old_mag_ff, old_mag_in;
   logic [WIDTH-1:0] mag_ff, mag_in;
   logic             neg_ff, neg_in;
   logic             reduce_ff, reduce_in;
   logic [WIDTH-1:0] dvd_ff, dvd_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] res_inv_ff, res_inv_in;
   logic             res_flag_ff, res_flag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   mi_pkg::rsp_type  rsp_ff, rsp_in;

   logic [EXT_W-1:0] val_ext, mod_ext, inv_ext;
   logic [WIDTH-1:0] val_w, mod_w;
   logic [WIDTH:0]   rem_sh, diff;
   logic             qbit;

   // operands taken in their low WIDTH bits
   assign val_ext = EXT_W'(req_data.value);
   assign mod_ext = EXT_W'(req_data.modulus);
   assign val_w   = val_ext[WIDTH-1:0];
   assign mod_w   = mod_ext[WIDTH-1:0];
   assign inv_ext = EXT_W'(res_inv_ff);

   // shared shift-subtract step, divisor in r_ff
   assign rem_sh = {rem_ff, dvd_ff[WIDTH-1]};
   assign diff   = rem_sh - {1'b0, r_ff};
   assign qbit   = ~diff[WIDTH];

   assign req_ready = (state_ff == mi_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      mod_in       = mod_ff;
      r_in         = r_ff;
      old_mag_in   = old_mag_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      reduce_in    = reduce_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      res_inv_in   = res_inv_ff;
      res_flag_in  = res_flag_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         mi_pkg::ST_IDLE: begin
            if (req_valid) begin
               mod_in    = mod_w;
               r_in      = mod_w;
               dvd_in    = val_w;
               rem_in    = '0;
               acc_in    = '0;
               cnt_in    = '0;
               reduce_in = 1'b1;
               if (mod_w == WIDTH'(1)) begin
                  res_inv_in  = WIDTH'(1);
                  res_flag_in = 1'b0;
                  state_in    = mi_pkg::ST_FINISH;
               end else if (mod_w == '0) begin
                  res_inv_in  = '0;
                  res_flag_in = 1'b1;
                  state_in    = mi_pkg::ST_FINISH;
               end else begin
                  state_in = mi_pkg::ST_DIVIDE;
               end
            end
         end

         mi_pkg::ST_DIVIDE: begin
            // one quotient bit per cycle, quotient times coefficient alongside
            rem_in = qbit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
            dvd_in = {dvd_ff[WIDTH-2:0], 1'b0};
            acc_in = {acc_ff[WIDTH-2:0], 1'b0} + (qbit ? mag_ff : '0);
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(WIDTH - 1)) begin
               state_in = mi_pkg::ST_UPDATE;
            end
         end

         mi_pkg::ST_UPDATE: begin
            rem_in = '0;
            acc_in = '0;
            cnt_in = '0;
            if (reduce_ff) begin
               // value reduced modulo the modulus
               reduce_in  = 1'b0;
               r_in       = rem_ff;
               old_mag_in = '0;
               mag_in     = WIDTH'(1);
               neg_in     = 1'b0;
               if (rem_ff != '0) begin
                  dvd_in   = mod_ff;
                  state_in = mi_pkg::ST_DIVIDE;
               end else begin
                  res_inv_in  = '0;
                  res_flag_in = 1'b1;
                  state_in    = mi_pkg::ST_FINISH;
               end
            end else begin
               // Euclid step: shift remainders and coefficients
               r_in       = rem_ff;
               old_mag_in = mag_ff;
               mag_in     = acc_ff + old_mag_ff;
               neg_in     = !neg_ff;
               if (rem_ff != '0) begin
                  dvd_in   = r_ff;
                  state_in = mi_pkg::ST_DIVIDE;
               end else begin
                  state_in = mi_pkg::ST_FINISH;
                  if (r_ff == WIDTH'(1)) begin
                     res_inv_in  = neg_ff ? (mod_ff - mag_ff) : mag_ff;
                     res_flag_in = 1'b0;
                  end else begin
                     res_inv_in  = '0;
                     res_flag_in = 1'b1;
                  end
               end
            end
         end

         mi_pkg::ST_FINISH: begin
            // hand the item to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.inverse    = inv_ext[mi_pkg::FIELD_W-1:0];
               rsp_in.no_inverse = res_flag_ff;
               rsp_valid_in      = 1'b1;
               state_in          = mi_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mi_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mi_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mod_ff      <= mod_in;
      r_ff        <= r_in;
      old_mag_ff  <= old_mag_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      reduce_ff   <= reduce_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      res_inv_ff  <= res_inv_in;
      res_flag_ff <= res_flag_in;
      rsp_ff      <= rsp_in;
   end

   // divisor is never zero while dividing
   assert property (@(posedge clock) disable iff (reset)
      state_ff == mi_pkg::ST_DIVIDE |-> r_ff != '0)
      else $error("divide started with zero divisor");

   // partial remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      state_ff == mi_pkg::ST_DIVIDE |-> rem_ff < r_ff)
      else $error("partial remainder not below divisor");

   // coefficient magnitude bounded by the modulus during Euclid steps
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == mi_pkg::ST_DIVIDE && !reduce_ff) |-> mag_ff <= mod_ff)
      else $error("coefficient exceeds modulus");

   // flagged results carry a zero inverse
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.no_inverse) |-> rsp_ff.inverse == '0)
      else $error("flagged result with nonzero inverse");

   // an accepted item always leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff != mi_pkg::ST_IDLE)
      else $error("accepted item not started");

endmodule
